// File: hdl/rebq_pkg.sv
// Shared types and constants for the rotary encoder and button qualifier.
// No dependencies; used by the core and by its port checker.
package rebq_pkg;

  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned CHANGE_W  = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned DIR_W     = 2;

  // A detent is four quadrature counts, so the detent is the count shifted by two.
  localparam int unsigned DETENT_SHIFT = 2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 1'b1;

  localparam logic signed [DIR_W-1:0] DIR_NONE = 2'sb00;
  localparam logic signed [DIR_W-1:0] DIR_UP   = 2'sb01;
  localparam logic signed [DIR_W-1:0] DIR_DOWN = 2'sb11;
  localparam logic signed [DIR_W-1:0] DIR_BAD  = 2'sb10;

  // Button transition, coded as {previous level, current level}.
  typedef enum logic [1:0] {
    BTN_HOLD = 2'b00,
    BTN_RISE = 2'b01,
    BTN_FALL = 2'b10,
    BTN_IDLE = 2'b11
  } btn_evt_t;

endpackage

// File: hdl/rotary_encoder_button_qualifier_core.sv
// Rotary encoder detent tracker and long-press button qualifier, top level.
// Depends on rebq_pkg for widths, reset values, register indexes and codes.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  in      | input     | in_valid/in_stall  | count_change, button_level, now_ms
//  out     | output    | out_valid/out_stall| step_direction, short_press, long_press,
//          |           |                    | long_release
//  cfg     | input     | cfg_wr_en          | cfg_index, cfg_wdata
//
// One poll is accepted per cycle while in_stall is low. A beat lands in the input register, is
// evaluated from there and is written into the output register when it advances.
// State updates with the registered result, so the next poll follows with no gap.
// Reset is synchronous and active low; it clears both valid flags and the tracker state and
// reloads both thresholds with their defaults. A stalled result holds the output register,
// and in_stall rises only while both registers are full and the result is stalled.
module rotary_encoder_button_qualifier_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Poll input channel.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [rebq_pkg::CHANGE_W-1:0] in_count_change,
  input  logic                                 in_button_level,
  input  logic        [rebq_pkg::TIME_W-1:0]   in_now_ms,
  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [rebq_pkg::DIR_W-1:0]    out_step_direction,
  output logic                                 out_short_press,
  output logic                                 out_long_press,
  output logic                                 out_long_release,
  // Configuration write port.
  input  logic                                 cfg_wr_en,
  input  logic        [rebq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [rebq_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int unsigned CW = rebq_pkg::COUNT_W;
  localparam int unsigned TW = rebq_pkg::TIME_W;
  localparam int unsigned SH = rebq_pkg::DETENT_SHIFT;

  // Configuration registers.
  logic [rebq_pkg::CFG_W-1:0] debounce_r;
  logic [rebq_pkg::CFG_W-1:0] long_press_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r        <= rebq_pkg::DEBOUNCE_RST;
      long_press_time_r <= rebq_pkg::LONG_PRESS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rebq_pkg::CFG_DEBOUNCE:   debounce_r        <= cfg_wdata;
        rebq_pkg::CFG_LONG_PRESS: long_press_time_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register. It may refill in the same cycle its beat moves on.
  logic                                 in_valid_r;
  logic signed [rebq_pkg::CHANGE_W-1:0] change_r;
  logic                                 level_r;
  logic        [TW-1:0]                 now_r;
  logic                                 advance;
  logic                                 in_take;

  assign advance  = in_valid_r && (!out_valid || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      change_r <= in_count_change;
      level_r  <= in_button_level;
      now_r    <= in_now_ms;
    end
  end

  // Tracker state.
  logic signed [CW-1:0] running_count_r, running_count_nxt;
  logic signed [CW-1:0] last_detent_r,   last_detent_nxt;
  logic                 prev_level_r;
  logic        [TW-1:0] press_start_r,   press_start_nxt;
  logic                 long_done_r,     long_done_nxt;

  // Encoder path: saturating add, truncating divide by four, one-step report.
  logic signed [CW:0]   sum_wide;
  logic signed [CW-1:0] sum_sat;
  logic signed [CW-1:0] sum_bias;
  logic signed [CW-1:0] detent;
  logic signed [rebq_pkg::DIR_W-1:0] dir_nxt;

  always_comb begin
    sum_wide = {running_count_r[CW-1], running_count_r}
             + {{(CW+1-rebq_pkg::CHANGE_W){change_r[rebq_pkg::CHANGE_W-1]}}, change_r};
    // The two top bits disagree only on overflow; the top bit then gives the side.
    if (sum_wide[CW] != sum_wide[CW-1]) begin
      sum_sat = sum_wide[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[CW-1:0];
    end
    // Adding three to a negative value before the arithmetic shift rounds toward zero.
    // A negative value cannot overflow from that bias.
    sum_bias = sum_sat + (sum_sat[CW-1] ? CW'((1 << SH) - 1) : CW'(0));
    detent   = sum_bias >>> SH;

    dir_nxt           = rebq_pkg::DIR_NONE;
    last_detent_nxt   = last_detent_r;
    running_count_nxt = sum_sat;
    if (detent != last_detent_r) begin
      dir_nxt           = (detent > last_detent_r) ? rebq_pkg::DIR_UP : rebq_pkg::DIR_DOWN;
      last_detent_nxt   = detent;
      // Realign the count to the start of the new detent.
      running_count_nxt = detent <<< SH;
    end
  end

  // Button path: edges are qualified by the time elapsed since the press began.
  logic [TW-1:0]        elapsed;
  logic                 past_debounce;
  logic                 at_debounce;
  logic                 at_long;
  rebq_pkg::btn_evt_t   btn_evt;
  logic                 sp_nxt, lp_nxt, lr_nxt;

  always_comb begin
    elapsed       = now_r - press_start_r;
    past_debounce = elapsed >  TW'(debounce_r);
    at_debounce   = elapsed >= TW'(debounce_r);
    at_long       = elapsed >= TW'(long_press_time_r);
    btn_evt       = rebq_pkg::btn_evt_t'({prev_level_r, level_r});

    press_start_nxt = press_start_r;
    long_done_nxt   = long_done_r;
    sp_nxt          = 1'b0;
    lp_nxt          = 1'b0;
    lr_nxt          = 1'b0;

    unique case (btn_evt)
      rebq_pkg::BTN_FALL: begin
        // A press that comes too soon after the last one is bounce.
        if (past_debounce) begin
          press_start_nxt = now_r;
          long_done_nxt   = 1'b0;
        end
      end
      rebq_pkg::BTN_RISE: begin
        if (at_debounce) begin
          sp_nxt        = !long_done_r;
          lr_nxt        = long_done_r;
          long_done_nxt = 1'b0;
        end
      end
      rebq_pkg::BTN_HOLD: begin
        if (!long_done_r && at_long) begin
          lp_nxt        = 1'b1;
          long_done_nxt = 1'b1;
        end
      end
      rebq_pkg::BTN_IDLE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_count_r <= '0;
      last_detent_r   <= '0;
      prev_level_r    <= 1'b1;
      press_start_r   <= '0;
      long_done_r     <= 1'b0;
    end else if (advance) begin
      running_count_r <= running_count_nxt;
      last_detent_r   <= last_detent_nxt;
      prev_level_r    <= level_r;
      press_start_r   <= press_start_nxt;
      long_done_r     <= long_done_nxt;
    end
  end

  // Output register.
  logic                               out_valid_r;
  logic signed [rebq_pkg::DIR_W-1:0]  dir_r;
  logic                               sp_r, lp_r, lr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dir_r <= dir_nxt;
      sp_r  <= sp_nxt;
      lp_r  <= lp_nxt;
      lr_r  <= lr_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_step_direction = dir_r;
  assign out_short_press    = sp_r;
  assign out_long_press     = lp_r;
  assign out_long_release   = lr_r;

endmodule

// File: hdl/rebq_checker.sv
// Port-level checker for the rotary encoder and button qualifier core, with its bind.
// Depends on rebq_pkg for the direction codes.
module rebq_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [rebq_pkg::DIR_W-1:0]    out_step_direction,
  input logic                                 out_short_press,
  input logic                                 out_long_press,
  input logic                                 out_long_release
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_step_direction)
      && $stable({out_short_press, out_long_press, out_long_release}))
    else $error("stalled result changed");

  // A poll reports at most one button event.
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_short_press, out_long_press, out_long_release}) <= 1)
    else $error("more than one button event in one result");

  // The direction is a single step or none.
  a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_step_direction != rebq_pkg::DIR_BAD)
    else $error("illegal step direction");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind rotary_encoder_button_qualifier_core rebq_checker u_rebq_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_step_direction (out_step_direction),
  .out_short_press    (out_short_press),
  .out_long_press     (out_long_press),
  .out_long_release   (out_long_release)
);
